### sv/ptt_pkg.sv
// Shared constants, codes and types for the periodic timer table.
package ptt_pkg;

   // Table geometry and field widths
   localparam int SLOTS  = 16;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int OCC_W  = $clog2(SLOTS + 1);
   localparam int CMD_W  = 4;
   localparam int KEY_W  = 16;
   localparam int VAL_W  = 16;
   localparam int KIND_W = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK       = 4'd0;
   localparam logic [CMD_W-1:0] CMD_ADD        = 4'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE     = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SET_TARGET = 4'd3;
   localparam logic [CMD_W-1:0] CMD_SET_COUNT  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_START      = 4'd5;
   localparam logic [CMD_W-1:0] CMD_STOP       = 4'd6;
   localparam logic [CMD_W-1:0] CMD_START_ALL  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_STOP_ALL   = 4'd8;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

   // Result of evaluating one slot in the shared unit
   typedef struct packed {
      logic [VAL_W-1:0] count_inc;
      logic             expire;
      logic             key_hit;
   } ptt_eval_type;

endpackage

### sv/ptt_slot_unit.sv
// Shared slot evaluator: count increment, expiry compare and key match.
module ptt_slot_unit (
   input  logic [ptt_pkg::VAL_W-1:0] count,
   input  logic [ptt_pkg::VAL_W-1:0] target,
   input  logic [ptt_pkg::KEY_W-1:0] slot_key,
   input  logic [ptt_pkg::KEY_W-1:0] req_key,
   output ptt_pkg::ptt_eval_type     eval
);
   import ptt_pkg::*;

   // Count wraps at its width; expiry when the new count reaches the target
   always_comb begin
      eval.count_inc = count + VAL_W'(1);
      eval.expire    = (eval.count_inc >= target);
      eval.key_hit   = (slot_key == req_key);
   end

endmodule

### sv/periodic_timer_table.sv
// Periodic timer table: top level with slot store, scan sequencer and result register.
//
// Usage:
//   Commands arrive on the req_ channel (valid/ready). Each command word is
//   answered on the rsp_ channel: a tick gives one expiry word per slot that
//   reaches its target, in slot order, then a done word; every other command
//   gives a single acknowledge word. The word that ends a command has
//   rsp_last set.
// Sequencing:
//   Every known command walks the 16 slots through one shared evaluator,
//   one slot per cycle unless a tick scan pauses on a stalled expiry, then
//   issues the done or acknowledge word once the result register is free.
//   Unknown commands skip the scan and go straight to the acknowledge word.
//   req_ready is high only between commands.
// Stalls:
//   A single result register sits on rsp_. The next command is accepted while
//   the last word still waits there; a tick scan pauses on a slot that expires
//   while the register is held by a stalled receiver.
// Reset:
//   Clears all valid and running marks, the occupancy count and the result
//   valid flag; the table comes up empty and ready.
module periodic_timer_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ptt_pkg::CMD_W-1:0]   req_command,
   input  logic [ptt_pkg::KEY_W-1:0]   req_key,
   input  logic [ptt_pkg::VAL_W-1:0]   req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ptt_pkg::KIND_W-1:0]  rsp_kind,
   output logic                        rsp_ok,
   output logic [ptt_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [ptt_pkg::KEY_W-1:0]   rsp_slot_key,
   output logic                        rsp_last
);
   import ptt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [1:0] ST_ACK  = 2'd3;

   // Sequencer and command registers
   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] found_idx_ff, found_idx_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic              any_ff, any_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;

   // Slot flags
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOTS-1:0]  run_ff, run_in;

   // Slot store
   logic [KEY_W-1:0]  key_mem [SLOTS];
   logic [VAL_W-1:0]  tgt_mem [SLOTS];
   logic [VAL_W-1:0]  cnt_mem [SLOTS];
   logic [SLOT_W-1:0] wr_idx;
   logic              key_we, tgt_we, cnt_we;
   logic [KEY_W-1:0]  key_wd;
   logic [VAL_W-1:0]  tgt_wd, cnt_wd;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              last_idx;
   logic              step;
   ptt_eval_type      eval;

   // Shared evaluator on the slot under the scan pointer
   ptt_slot_unit u_unit (
      .count    (cnt_mem[idx_ff]),
      .target   (tgt_mem[idx_ff]),
      .slot_key (key_mem[idx_ff]),
      .req_key  (key_ff),
      .eval     (eval)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_slot_key = rsp_key_ff;
   assign rsp_last     = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_idx = (idx_ff == SLOT_W'(SLOTS - 1));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      any_in       = any_ff;
      occ_in       = occ_ff;
      valid_in     = valid_ff;
      run_in       = run_ff;
      wr_idx       = idx_ff;
      key_we       = 1'b0;
      tgt_we       = 1'b0;
      cnt_we       = 1'b0;
      key_wd       = '0;
      tgt_wd       = '0;
      cnt_wd       = '0;
      step         = 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in       = req_command;
               key_in       = req_key;
               val_in       = req_value;
               idx_in       = '0;
               found_in     = 1'b0;
               found_idx_in = '0;
               free_in      = 1'b0;
               free_idx_in  = '0;
               any_in       = 1'b0;
               state_in     = (req_command > CMD_STOP_ALL) ? ST_ACK : ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (cmd_ff == CMD_TICK) begin
               // count up running slots; expiry needs the result register
               if (valid_ff[idx_ff] && run_ff[idx_ff]) begin
                  if (eval.expire) begin
                     if (out_free) begin
                        cnt_we       = 1'b1;
                        cnt_wd       = '0;
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_EXPIRE;
                        rsp_ok_in    = 1'b1;
                        rsp_slot_in  = idx_ff;
                        rsp_key_in   = key_mem[idx_ff];
                        rsp_last_in  = 1'b0;
                     end else begin
                        step = 1'b0;
                     end
                  end else begin
                     cnt_we = 1'b1;
                     cnt_wd = eval.count_inc;
                  end
               end
            end else begin
               // lookup: first key match, first free slot, any occupied; start/stop all set run marks
               if (valid_ff[idx_ff]) begin
                  any_in = 1'b1;
                  if (eval.key_hit && !found_ff) begin
                     found_in     = 1'b1;
                     found_idx_in = idx_ff;
                  end
                  if (cmd_ff == CMD_START_ALL || cmd_ff == CMD_STOP_ALL) begin
                     run_in[idx_ff] = (cmd_ff == CMD_START_ALL);
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = idx_ff;
               end
            end
            if (step) begin
               idx_in = idx_ff + SLOT_W'(1);
               if (last_idx) begin
                  state_in = (cmd_ff == CMD_TICK) ? ST_DONE : ST_ACK;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DONE;
               rsp_ok_in    = 1'b1;
               rsp_slot_in  = '0;
               rsp_key_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_ok_in    = 1'b0;
               rsp_slot_in  = '0;
               rsp_key_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               unique case (cmd_ff) inside
                  CMD_ADD: begin
                     if (occ_ff != OCC_W'(SLOTS) && !found_ff && free_ff) begin
                        wr_idx                = free_idx_ff;
                        valid_in[free_idx_ff] = 1'b1;
                        run_in[free_idx_ff]   = 1'b0;
                        key_we                = 1'b1;
                        key_wd                = key_ff;
                        tgt_we                = 1'b1;
                        tgt_wd                = val_ff;
                        cnt_we                = 1'b1;
                        cnt_wd                = '0;
                        occ_in                = occ_ff + OCC_W'(1);
                        rsp_ok_in             = 1'b1;
                        rsp_slot_in           = free_idx_ff;
                        rsp_key_in            = key_ff;
                     end
                  end
                  CMD_DELETE, CMD_SET_TARGET, CMD_SET_COUNT, CMD_START, CMD_STOP: begin
                     if (found_ff) begin
                        wr_idx      = found_idx_ff;
                        rsp_ok_in   = 1'b1;
                        rsp_slot_in = found_idx_ff;
                        rsp_key_in  = key_ff;
                        case (cmd_ff)
                           CMD_DELETE: begin
                              valid_in[found_idx_ff] = 1'b0;
                              run_in[found_idx_ff]   = 1'b0;
                              key_we                 = 1'b1;
                              tgt_we                 = 1'b1;
                              cnt_we                 = 1'b1;
                              if (occ_ff != '0) begin
                                 occ_in = occ_ff - OCC_W'(1);
                              end
                           end
                           CMD_SET_TARGET: begin
                              tgt_we = 1'b1;
                              tgt_wd = val_ff;
                           end
                           CMD_SET_COUNT: begin
                              cnt_we = 1'b1;
                              cnt_wd = val_ff;
                           end
                           CMD_START: run_in[found_idx_ff] = 1'b1;
                           default:   run_in[found_idx_ff] = 1'b0;
                        endcase
                     end
                  end
                  CMD_START_ALL, CMD_STOP_ALL: begin
                     rsp_ok_in = any_ff;
                  end
                  default: begin
                     rsp_ok_in = 1'b0;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         run_ff       <= '0;
         occ_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         run_ff       <= run_in;
         occ_ff       <= occ_in;
      end
   end

   // Scan bookkeeping and result payload
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      any_ff       <= any_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Slot store writes, one slot per cycle
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_idx] <= key_wd;
      end
      if (tgt_we) begin
         tgt_mem[wr_idx] <= tgt_wd;
      end
      if (cnt_we) begin
         cnt_mem[wr_idx] <= cnt_wd;
      end
   end

endmodule

### sv/ptt_checker.sv
// Port-level checks for the periodic timer table, bound to the top level.
module ptt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [ptt_pkg::CMD_W-1:0]   req_command,
   input logic [ptt_pkg::KEY_W-1:0]   req_key,
   input logic [ptt_pkg::VAL_W-1:0]   req_value,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ptt_pkg::KIND_W-1:0]  rsp_kind,
   input logic                        rsp_ok,
   input logic [ptt_pkg::SLOT_W-1:0]  rsp_slot,
   input logic [ptt_pkg::KEY_W-1:0]   rsp_slot_key,
   input logic                        rsp_last
);
   import ptt_pkg::*;

   // Ready drops in the cycle after a command word is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready did not drop after a command word");

   // A waiting command word holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_command) && $stable(req_key)
                                     && $stable(req_value)))
      else $error("command word changed while waiting");

   // Done words close a tick and always succeed
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_DONE) |-> (rsp_last && rsp_ok && rsp_slot_key == '0))
      else $error("malformed tick done word");

   // Expiry words are never the end of a command and always carry ok
   a_expire_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_EXPIRE) |-> (!rsp_last && rsp_ok))
      else $error("malformed expiry word");

   // A stalled result word holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_slot)
                                     && $stable(rsp_slot_key) && $stable(rsp_last)))
      else $error("result word changed while stalled");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (.*);

### tb/sv/ptt_checker.sv
// Scoreboard for the periodic timer table: predicts every result word and checks rsp_.
module ptt_scoreboard (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [ptt_pkg::CMD_W-1:0]  req_command,
   input  logic [ptt_pkg::KEY_W-1:0]  req_key,
   input  logic [ptt_pkg::VAL_W-1:0]  req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [ptt_pkg::KIND_W-1:0] rsp_kind,
   input  logic                       rsp_ok,
   input  logic [ptt_pkg::SLOT_W-1:0] rsp_slot,
   input  logic [ptt_pkg::KEY_W-1:0]  rsp_slot_key,
   input  logic                       rsp_last,
   output int                         fail_count,
   output int                         words_due,
   output int                         words_checked,
   output int                         expiries_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import ptt_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              ok;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  slot_key;
      logic              last;
   } timer_word_type;

   // Words the table still owes, oldest first
   timer_word_type due_words [$];

   // Shadow copy of the slot table
   logic             in_use   [SLOTS];
   logic [KEY_W-1:0] held_key [SLOTS];
   logic [VAL_W-1:0] period_of[SLOTS];
   logic [VAL_W-1:0] count_of [SLOTS];
   logic             armed    [SLOTS];
   int               filled;

   function automatic void push_word(logic [KIND_W-1:0] kind, logic ok,
                                     logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key,
                                     logic last);
      due_words.push_back(timer_word_type'{kind, ok, slot, key, last});
   endfunction

   // Lowest valid slot holding the key, -1 when absent
   function automatic int find_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (in_use[i] && held_key[i] == key)
            return i;
      return -1;
   endfunction

   // Update the shadow table for one command word and queue the words it causes
   function automatic void apply_timer_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                               logic [VAL_W-1:0] val);
      int  hit;
      int  open_slot;
      bit  any;
      hit = find_slot(key);
      case (cmd)
         CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (in_use[i] && armed[i]) begin
                  count_of[i] = count_of[i] + VAL_W'(1);
                  if (count_of[i] >= period_of[i]) begin
                     count_of[i] = '0;
                     push_word(KIND_EXPIRE, 1'b1, SLOT_W'(i), held_key[i], 1'b0);
                  end
               end
            end
            push_word(KIND_DONE, 1'b1, '0, '0, 1'b1);
         end
         CMD_ADD: begin
            open_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!in_use[i])
                  open_slot = i;
            if (filled >= SLOTS || hit >= 0 || open_slot < 0) begin
               push_word(KIND_ACK, 1'b0, '0, '0, 1'b1);
            end else begin
               in_use[open_slot]    = 1'b1;
               held_key[open_slot]  = key;
               period_of[open_slot] = val;
               count_of[open_slot]  = '0;
               armed[open_slot]     = 1'b0;
               filled++;
               push_word(KIND_ACK, 1'b1, SLOT_W'(open_slot), key, 1'b1);
            end
         end
         CMD_START_ALL, CMD_STOP_ALL: begin
            any = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (in_use[i]) begin
                  armed[i] = (cmd == CMD_START_ALL);
                  any = 1'b1;
               end
            end
            push_word(KIND_ACK, any, '0, '0, 1'b1);
         end
         CMD_DELETE, CMD_SET_TARGET, CMD_SET_COUNT, CMD_START, CMD_STOP: begin
            if (hit < 0) begin
               push_word(KIND_ACK, 1'b0, '0, '0, 1'b1);
            end else begin
               push_word(KIND_ACK, 1'b1, SLOT_W'(hit), held_key[hit], 1'b1);
               case (cmd)
                  CMD_DELETE: begin
                     in_use[hit]    = 1'b0;
                     held_key[hit]  = '0;
                     period_of[hit] = '0;
                     count_of[hit]  = '0;
                     armed[hit]     = 1'b0;
                     if (filled > 0)
                        filled--;
                  end
                  CMD_SET_TARGET: period_of[hit] = val;
                  CMD_SET_COUNT:  count_of[hit]  = val;
                  CMD_START:      armed[hit]     = 1'b1;
                  default:        armed[hit]     = 1'b0;
               endcase
            end
         end
         // codes above stop all are refused
         default: push_word(KIND_ACK, 1'b0, '0, '0, 1'b1);
      endcase
   endfunction

   function automatic bit field_ok(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: rsp_%s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Check result words first: a word leaving at this edge never belongs to a
   // command accepted at the same edge
   always @(posedge clock) begin : watch
      timer_word_type want;
      bit             good;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            in_use[i]    = 1'b0;
            held_key[i]  = '0;
            period_of[i] = '0;
            count_of[i]  = '0;
            armed[i]     = 1'b0;
         end
         filled = 0;
         due_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (rsp_kind == KIND_EXPIRE)
               expiries_seen++;
            if (due_words.size() == 0) begin
               $display("%0t ns: unexpected word kind %0d slot %0d key 0x%0h",
                        $time, rsp_kind, rsp_slot, rsp_slot_key);
               fail_count++;
            end else begin
               want = due_words.pop_front();
               good = field_ok("kind", KEY_W'(want.kind), KEY_W'(rsp_kind))
                    & field_ok("ok", KEY_W'(want.ok), KEY_W'(rsp_ok))
                    & field_ok("slot", KEY_W'(want.slot), KEY_W'(rsp_slot))
                    & field_ok("slot_key", want.slot_key, rsp_slot_key)
                    & field_ok("last", KEY_W'(want.last), KEY_W'(rsp_last));
               if (!good)
                  fail_count++;
            end
         end
         if (req_valid && req_ready)
            apply_timer_command(req_command, req_key, req_value);
      end
      words_due = due_words.size();
   end

endmodule

### tb/sv/tb.sv
// Testbench top for the periodic timer table: clock, reset, command stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptt_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int POOL_SIZE    = 24;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command;
   logic [KEY_W-1:0]  req_key;
   logic [VAL_W-1:0]  req_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [KIND_W-1:0] rsp_kind;
   logic              rsp_ok;
   logic [SLOT_W-1:0] rsp_slot;
   logic [KEY_W-1:0]  rsp_slot_key;
   logic              rsp_last;

   int fail_count;
   int words_due;
   int words_checked;
   int expiries_seen;

   int          words_sent;
   int          quiet_cycles;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned send_pct[3] = '{27, 86, 0};
   int unsigned recv_pct[3] = '{86, 27, 0};
   logic [KEY_W-1:0] key_pool[POOL_SIZE];

   periodic_timer_table i_dut (.*);

   ptt_scoreboard i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: ends a run in which nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d words due", quiet_cycles, words_due);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one command word; starts and returns at a falling edge
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                            logic [VAL_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_key     <= key;
      req_value   <= val;
      do
         @(posedge clock);
      while (!req_ready);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(9) == 0)
         return KEY_W'($urandom);
      return key_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   // Mostly short periods so slots expire often
   function automatic logic [VAL_W-1:0] pick_period();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 6)
         return VAL_W'($urandom_range(3));
      if (roll < 8)
         return VAL_W'($urandom_range(12, 4));
      return VAL_W'($urandom);
   endfunction

   // Counts near zero, near the wrap point, or anywhere
   function automatic logic [VAL_W-1:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 6)
         return VAL_W'($urandom_range(3));
      if (roll < 8)
         return {VAL_W{1'b1}} - VAL_W'($urandom_range(2));
      return VAL_W'($urandom);
   endfunction

   task automatic send_random_word();
      int unsigned      roll;
      logic [CMD_W-1:0] cmd;
      roll = $urandom_range(99);
      if (roll < 25)      cmd = CMD_TICK;
      else if (roll < 39) cmd = CMD_ADD;
      else if (roll < 51) cmd = CMD_DELETE;
      else if (roll < 59) cmd = CMD_SET_TARGET;
      else if (roll < 67) cmd = CMD_SET_COUNT;
      else if (roll < 79) cmd = CMD_START;
      else if (roll < 84) cmd = CMD_STOP;
      else if (roll < 92) cmd = CMD_START_ALL;
      else if (roll < 95) cmd = CMD_STOP_ALL;
      else                cmd = CMD_W'($urandom_range(2**CMD_W - 1, CMD_STOP_ALL + 1));
      send_word(cmd, pick_key(), (cmd == CMD_SET_COUNT) ? pick_count() : pick_period());
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = CMD_TICK;
      req_key       = '0;
      req_value     = '0;
      send_idle_pct = send_pct[0];
      recv_idle_pct = recv_pct[0];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table: tick, group commands and lookups find nothing
      send_word(CMD_TICK, 16'h0000, 16'h0000);
      send_word(CMD_START_ALL, 16'h0000, 16'h0000);
      send_word(CMD_STOP_ALL, 16'h0000, 16'h0000);
      send_word(CMD_DELETE, 16'h0000, 16'h0000);
      // Key zero is ordinary; extreme key and period; duplicate add refused
      send_word(CMD_ADD, 16'h0000, 16'h0000);
      send_word(CMD_ADD, 16'hFFFF, 16'hFFFF);
      send_word(CMD_ADD, 16'h0000, 16'h0005);
      send_word(CMD_START, 16'h0000, 16'h0000);
      send_word(CMD_START, 16'hFFFF, 16'h0000);
      // Zero period expires every tick; count reaching the top expires
      send_word(CMD_SET_COUNT, 16'hFFFF, 16'hFFFE);
      send_word(CMD_TICK, 16'h0000, 16'h0000);
      // Count wraps to zero without expiring
      send_word(CMD_SET_COUNT, 16'hFFFF, 16'hFFFF);
      send_word(CMD_TICK, 16'hFFFF, 16'hFFFF);
      // Unknown codes
      send_word(CMD_W'(CMD_STOP_ALL + 1), 16'hA5A5, 16'h5A5A);
      send_word(CMD_W'(2**CMD_W - 1), 16'h5A5A, 16'hA5A5);
      send_word(CMD_STOP, 16'h0000, 16'h0000);
      send_word(CMD_STOP_ALL, 16'h0000, 16'h0000);
      send_word(CMD_START_ALL, 16'h0000, 16'h0000);
      send_word(CMD_SET_TARGET, 16'h0000, 16'h0001);
      send_word(CMD_TICK, 16'h0000, 16'h0000);
      // Freed slot is reused first
      send_word(CMD_DELETE, 16'h0000, 16'h0000);
      send_word(CMD_ADD, 16'h1234, 16'h0003);
      send_word(CMD_SET_TARGET, 16'h7777, 16'h0002);
      send_word(CMD_STOP, 16'hFFFF, 16'h0000);
      send_word(CMD_TICK, 16'h0000, 16'h0000);

      // Random phases: fill the table from a key pool, then mixed traffic
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pct[phase];
         recv_idle_pct = recv_pct[phase];
         foreach (key_pool[i])
            key_pool[i] = KEY_W'($urandom);
         repeat (18) send_word(CMD_ADD, pick_key(), pick_period());
         repeat (66) send_random_word();
      end
      req_valid <= 1'b0;
      recv_idle_pct = 0;

      while (words_due != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("summary: %0d command words over three pacing phases, %0d result words checked",
               words_sent, words_checked);
      $display("summary: %0d slot expiries seen, %0d mismatching words", expiries_seen,
               fail_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
sv/ptt_pkg.sv
sv/ptt_slot_unit.sv
sv/periodic_timer_table.sv
sv/ptt_checker.sv
tb/sv/ptt_checker.sv
tb/sv/tb.sv
